[rtl/assert_macros.svh]
// Assertion macros shared by the RTL files.
// Included by modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[rtl/fp64ri_pkg.sv]
// Types and constants for the binary64 round-to-integer unit.
// No dependencies.
`default_nettype none
package fp64ri_pkg;
    localparam int FRAC_BITS = 52;
    localparam int EXP_BIAS  = 1023;
    localparam logic [10:0] EXP_MAX = 11'h7FF;

    typedef enum logic [1:0] {
        MODE_FLOOR = 2'd0,
        MODE_CEIL  = 2'd1,
        MODE_TRUNC = 2'd2,
        MODE_ROUND = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DOMAIN   = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    // fraction class of the discarded part
    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_BELOW = 2'd1,
        CLS_HALF  = 2'd2,
        CLS_ABOVE = 2'd3
    } cls_t;

    typedef struct packed {
        logic        to_int;
        mode_t       mode;
        logic [63:0] x;
    } req_t;
endpackage
`default_nettype wire

[rtl/fp64ri_round.sv]
// Combinational rounding datapath: magnitude rounding, real repack and
// integer range check. Depends on fp64ri_pkg.
`default_nettype none
module fp64ri_round #(
    parameter int INT_WIDTH = 31
) (
    input  fp64ri_pkg::req_t       req,
    output logic [63:0]            real_bits,
    output logic [INT_WIDTH-1:0]   int_value,
    output fp64ri_pkg::status_t    status
);
    import fp64ri_pkg::*;

    logic        neg;
    logic [10:0] expo;
    logic [51:0] man;
    logic [52:0] sig;
    logic [63:0] q;
    logic [63:0] mag;
    cls_t        cls;
    logic        inc;
    logic        rneg;
    logic [52:0] rmask;
    logic [52:0] half;
    logic [52:0] rem;
    logic [5:0]  sh;
    logic [5:0]  lz;
    logic [5:0]  p;
    logic [63:0] lim;
    logic [63:0] shifted;
    logic        special_real;
    logic        big;

    assign neg  = req.x[63];
    assign expo = req.x[62:52];
    assign man  = req.x[51:0];
    assign sig  = {1'b1, man};
    assign lim  = 64'd1 << (INT_WIDTH - 1);

    always_comb
    begin
        q     = '0;
        cls   = CLS_NONE;
        sh    = '0;
        rmask = '0;
        half  = '0;
        rem   = '0;
        if (expo == 11'd0) begin
            // zero or subnormal
            cls = (man == '0) ? CLS_NONE : CLS_BELOW;
        end else if (expo >= 11'(EXP_BIAS + FRAC_BITS)) begin
            q = 64'(sig) << 6'(expo - 11'(EXP_BIAS + FRAC_BITS));
        end else if (expo < 11'(EXP_BIAS)) begin
            if (expo == 11'(EXP_BIAS - 1))
                cls = (man == '0) ? CLS_HALF : CLS_ABOVE;
            else
                cls = CLS_BELOW;
        end else begin
            sh    = 6'(11'(EXP_BIAS + FRAC_BITS) - expo);
            rmask = (53'd1 << sh) - 53'd1;
            half  = 53'd1 << (sh - 6'd1);
            rem   = sig & rmask;
            q     = 64'(sig >> sh);
            if (rem == '0)      cls = CLS_NONE;
            else if (rem < half) cls = CLS_BELOW;
            else if (rem == half) cls = CLS_HALF;
            else                 cls = CLS_ABOVE;
        end
        case (req.mode)
            MODE_FLOOR: inc = neg && (cls != CLS_NONE);
            MODE_CEIL:  inc = !neg && (cls != CLS_NONE);
            MODE_TRUNC: inc = 1'b0;
            MODE_ROUND: inc = (cls == CLS_ABOVE) || ((cls == CLS_HALF) && q[0]);
            default:    inc = 1'b0;
        endcase
        mag = q + 64'(inc);
    end

    // leading one of a magnitude below 2^54
    always_comb
    begin
        lz = '0;
        for (int i = 0; i < 54; i++)
            if (mag[i]) lz = 6'(i);
    end
    assign p = lz;
    assign shifted = mag << (6'd52 - p);

    assign special_real = (expo == EXP_MAX) || (expo == '0 && man == '0)
                          || (expo >= 11'(EXP_BIAS + FRAC_BITS));
    assign big = expo >= 11'(EXP_BIAS + 63);

    always_comb
    begin
        real_bits = '0;
        int_value = '0;
        status    = ST_OK;
        rneg      = neg;
        if (!req.to_int) begin
            if (special_real) begin
                real_bits = req.x;
            end else begin
                if ((req.mode == MODE_ROUND) && (mag == '0) && (cls != CLS_NONE))
                    rneg = 1'b0;
                if (mag == '0)
                    real_bits = {rneg, 63'd0};
                else
                    real_bits = {rneg, 11'(11'(EXP_BIAS) + 11'(p)), shifted[51:0]};
            end
        end else if (expo == EXP_MAX) begin
            status = (man != '0) ? ST_DOMAIN : ST_OVERFLOW;
        end else if (big && !(neg && expo == 11'(EXP_BIAS + 63) && man == '0)) begin
            status = ST_OVERFLOW;
        end else begin
            if (big) begin
                // exactly -2^63
                if (64'h8000_0000_0000_0000 > lim) status = ST_OVERFLOW;
                else int_value = INT_WIDTH'(64'd0 - 64'h8000_0000_0000_0000);
            end else if ((!neg && mag >= lim) || (neg && mag > lim)) begin
                status = ST_OVERFLOW;
            end else begin
                int_value = INT_WIDTH'(neg ? (64'd0 - mag) : mag);
            end
        end
    end
endmodule
`default_nettype wire

[rtl/fp64_round_to_integer_unit.sv]
// Top level of the binary64 round-to-integer unit: input register, datapath,
// result register with stream handshake. Depends on fp64ri_pkg, fp64ri_round.
// One request per cycle; a request accepted by the input register passes the
// datapath into the result register, whose output is the result on m_tdata.
// Throughput is set by the single datapath stage and holds as long as the
// result side takes each result.
`default_nettype none
`include "assert_macros.svh"
module fp64_round_to_integer_unit #(
    parameter int INT_WIDTH = 31
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [71:0]          s_tdata,  // cmd[2:0], operand_bits[66:3]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // real_bits, int_value, status, zero pad to whole bytes
    output logic [((INT_WIDTH+73)/8)*8-1:0] m_tdata
);
    import fp64ri_pkg::*;

    localparam int OUT_W = ((INT_WIDTH + 73) / 8) * 8;

    logic                 in_vld_reg;
    req_t                 in_req_reg;
    logic                 out_vld_reg;
    logic [63:0]          real_reg;
    logic [INT_WIDTH-1:0] int_reg;
    status_t              st_reg;
    logic [63:0]          real_next;
    logic [INT_WIDTH-1:0] int_next;
    status_t              st_next;
    logic                 out_free;
    logic                 unused_pad;

    assign out_free = !out_vld_reg || m_tready;
    assign s_tready = !in_vld_reg || out_free;
    assign unused_pad = ^s_tdata[71:67];

    fp64ri_round #(.INT_WIDTH(INT_WIDTH)) u_round (
        .req       (in_req_reg),
        .real_bits (real_next),
        .int_value (int_next),
        .status    (st_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_tready) in_vld_reg <= s_tvalid;
            if (out_free) out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_req_reg <= '{to_int: s_tdata[2], mode: mode_t'(s_tdata[1:0]),
                            x: s_tdata[66:3]};
        if (out_free && in_vld_reg) begin
            real_reg <= real_next;
            int_reg  <= int_next;
            st_reg   <= st_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = OUT_W'({st_reg, int_reg, real_reg});

    `ASSERT_NEXT(a_out_follows, clk, rst_n, in_vld_reg && out_free, m_tvalid)
    `ASSERT_IMPL(a_err_zero, clk, rst_n, m_tvalid && st_reg != ST_OK, int_reg == '0)
    `ASSERT_IMPL(a_stall_in, clk, rst_n, in_vld_reg && !out_free, !s_tready)
endmodule
`default_nettype wire
